@@ rtl/mkrs_pkg.sv @@
// package for the multi-key record sorter: record types, key codes, key compare
// no dependencies
package mkrs_pkg;

    localparam int ID_W    = 20;
    localparam int NAME_W  = 64;
    localparam int GRADE_W = 16;
    localparam int KEY_W   = 2;

    localparam logic [KEY_W-1:0] KEY_ID    = 2'd0;
    localparam logic [KEY_W-1:0] KEY_NAME  = 2'd1;
    localparam logic [KEY_W-1:0] KEY_GRADE = 2'd2;

    localparam logic [0:0] REG_SORT_KEY = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [NAME_W-1:0]  name;
        logic [GRADE_W-1:0] grade;
    } t_rec;

    // item from loader to sorter: a record with its store, batch end and overflow flags
    typedef struct packed {
        t_rec rec;
        logic store;
        logic last;
        logic ovf;
    } t_cmd;

    // true when a belongs strictly before b
    function automatic logic rec_before(input t_rec a, input t_rec b,
                                        input logic [KEY_W-1:0] key);
        logic res;
        begin
            res = (a.id < b.id);
            case (key)
                KEY_ID:    res = (a.id < b.id);
                KEY_NAME:  if (a.name != b.name) res = (a.name < b.name);
                KEY_GRADE: if (a.grade != b.grade) res = (a.grade < b.grade);
                default:   res = 1'b0;
            endcase
            return res;
        end
    endfunction

endpackage

@@ rtl/mkrs_if.sv @@
// valid/ready channel interfaces for record input and sorted output
// uses mkrs_pkg
interface mkrs_in_if import mkrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    record_id;
    logic [NAME_W-1:0]  record_name;
    logic [GRADE_W-1:0] record_grade;
    logic               last_item;
    modport source (output valid, record_id, record_name, record_grade, last_item,
                    input ready);
    modport sink (input valid, record_id, record_name, record_grade, last_item,
                  output ready);
endinterface

interface mkrs_out_if import mkrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    out_id;
    logic [NAME_W-1:0]  out_name;
    logic [GRADE_W-1:0] out_grade;
    logic               out_last;
    logic               dropped;
    modport source (output valid, out_id, out_name, out_grade, out_last, dropped,
                    input ready);
    modport sink (input valid, out_id, out_name, out_grade, out_last, dropped,
                  output ready);
endinterface

@@ rtl/multi_key_record_sorter.sv @@
// top level of the multi-key record sorter: config register, loader, queue, sorter
// uses mkrs_pkg, mkrs_if, mkrs_loader, mkrs_fifo, mkrs_sorter
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    record_id, record_name, record_grade, last_item
// out_ch    out  valid/ready    out_id, out_name, out_grade, out_last, dropped
// apb       in   psel/penable   sort_key at address 0
//
// a record is inserted into the cell chain at its sorted place; the sorted batch
// drains one record per cycle from cell 0 while out_ch is ready. while the chain
// drains, input stalls once the two-entry queue fills. reset is synchronous and
// clears counts and state; cell contents are not reset.
module multi_key_record_sorter import mkrs_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mkrs_in_if.sink     in_ch,
    mkrs_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [KEY_W-1:0] r_key;
    t_cmd f_cmd, b_cmd;
    logic f_valid, f_ready, b_valid, b_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SORT_KEY) ? {30'd0, r_key} : 32'd0;

    // sort key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= KEY_ID;
        end else if (psel && penable && pwrite && paddr == REG_SORT_KEY) begin
            r_key <= pwdata[KEY_W-1:0];
        end
    end

    mkrs_loader #(.CAPACITY(CAPACITY), .NAME_BYTES(NAME_BYTES)) u_load (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd(f_cmd), .o_cmd_valid(f_valid), .i_cmd_ready(f_ready));

    mkrs_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(f_cmd), .i_valid(f_valid), .o_ready(f_ready),
        .o_cmd(b_cmd), .o_valid(b_valid), .i_ready(b_ready));

    mkrs_sorter #(.CAPACITY(CAPACITY)) u_sort (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_key(r_key),
        .i_cmd(b_cmd), .i_valid(b_valid), .o_ready(b_ready), .out_ch(out_ch));
endmodule

@@ rtl/mkrs_loader.sv @@
// front part: counts records, masks names, flags overflow, emits commands
// uses mkrs_pkg
module mkrs_loader import mkrs_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int NAME_BYTES = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mkrs_in_if.sink in_ch,
    output t_cmd   o_cmd,
    output logic   o_cmd_valid,
    input  logic   i_cmd_ready
);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [NAME_W-1:0] NAME_MASK =
        ~(NAME_W'(0)) << (8 * (8 - NAME_BYTES));

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic             full;

    assign full         = (r_count == CNT_W'(CAPACITY));
    assign in_ch.ready  = i_cmd_ready;
    assign o_cmd_valid  = in_ch.valid;

    // classify the item
    always_comb begin
        o_cmd.rec.id    = in_ch.record_id;
        o_cmd.rec.name  = in_ch.record_name & NAME_MASK;
        o_cmd.rec.grade = in_ch.record_grade;
        o_cmd.store     = !full;
        o_cmd.last      = in_ch.last_item;
        o_cmd.ovf       = r_ovf | full;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (in_ch.valid && i_cmd_ready) begin
            if (in_ch.last_item) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end else if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end
endmodule

@@ rtl/mkrs_fifo.sv @@
// short queue between loader and sorter
// uses mkrs_pkg
module mkrs_fifo import mkrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  logic i_valid,
    output logic o_ready,
    output t_cmd o_cmd,
    output logic o_valid,
    input  logic i_ready
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_cmd;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/mkrs_sorter.sv @@
// back part: insertion cell chain holding the sorted batch, then drain
// uses mkrs_pkg
module mkrs_sorter import mkrs_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [KEY_W-1:0] i_key,
    input  t_cmd            i_cmd,
    input  logic            i_valid,
    output logic            o_ready,
    mkrs_out_if.source      out_ch
);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [1:0] ST_LOAD = 2'd0, ST_DRAIN = 2'd1;

    t_rec             r_cell [CAPACITY];
    logic [CNT_W-1:0] r_n;
    logic [1:0]       r_st;
    logic             r_ovf;
    logic [CAPACITY-1:0] bef, occ;
    logic             ins, shift;

    assign o_ready = (r_st == ST_LOAD);
    assign ins     = i_valid && o_ready && i_cmd.store;
    assign shift   = (r_st == ST_DRAIN) && out_ch.ready;

    // each cell compares the new record with its own
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            occ[k] = (CNT_W'(k) < r_n);
            bef[k] = occ[k] && rec_before(i_cmd.rec, r_cell[k], i_key);
        end
    end

    // cells: insert keeps order, drain shifts toward cell 0
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAPACITY; k++) begin
            if (ins) begin
                if (k == 0) begin
                    if (bef[0] || !occ[0]) r_cell[0] <= i_cmd.rec;
                end else if (bef[k-1]) begin
                    r_cell[k] <= r_cell[k-1];
                end else if (bef[k] || !occ[k]) begin
                    r_cell[k] <= i_cmd.rec;
                end
            end else if (shift && k < CAPACITY - 1) begin
                r_cell[k] <= r_cell[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0; r_st <= ST_LOAD; r_ovf <= 1'b0;
        end else begin
            unique case (r_st)
                ST_LOAD: if (i_valid) begin
                    if (i_cmd.store) r_n <= r_n + CNT_W'(1);
                    if (i_cmd.last) begin
                        r_ovf <= i_cmd.ovf;
                        if (i_cmd.store || r_n != '0) r_st <= ST_DRAIN;
                    end
                end
                ST_DRAIN: if (out_ch.ready) begin
                    r_n <= r_n - CNT_W'(1);
                    if (r_n == CNT_W'(1)) r_st <= ST_LOAD;
                end
                default: r_st <= ST_LOAD;
            endcase
        end
    end

    assign out_ch.valid     = (r_st == ST_DRAIN);
    assign out_ch.out_id    = r_cell[0].id;
    assign out_ch.out_name  = r_cell[0].name;
    assign out_ch.out_grade = r_cell[0].grade;
    assign out_ch.out_last  = (r_n == CNT_W'(1));
    assign out_ch.dropped   = r_ovf;
endmodule
